>>> sv/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside reset.
`define FCMC_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property at every edge, reset included.
`define FCMC_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> sv/fcmc_pkg.sv
`default_nettype none
package fcmc_pkg;

   localparam int ENTRIES       = 128;
   localparam int WORD_BITS     = 16;
   localparam int SLOT_BITS     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CAP_BITS      = 8;
   localparam int OCC_BITS      = ($clog2(ENTRIES + 1) > CAP_BITS) ? $clog2(ENTRIES + 1)
                                                                   : CAP_BITS;
   localparam int COUNT_BITS    = 24;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [CSR_ADDR_BITS-3:0] REG_CAPACITY = '0;
   localparam logic [CAP_BITS-1:0]      CAP_RESET    = 8'd128;
   localparam logic [OCC_BITS-1:0]      OCC_ONE      = OCC_BITS'(1);
   localparam logic [OCC_BITS-1:0]      OCC_ENTRIES  = OCC_BITS'(ENTRIES);
   localparam logic [COUNT_BITS-1:0]    COUNT_MAX    = {COUNT_BITS{1'b1}};

   typedef struct packed {
      logic                 valid;
      logic                 hit;
      logic [WORD_BITS-1:0] word;
   } probe_type;

   typedef struct packed {
      logic                 en;
      logic [SLOT_BITS-1:0] slot;
      logic [WORD_BITS-1:0] word;
   } write_type;

endpackage
`default_nettype wire

>>> sv/fifo_cache_miss_counter.sv
// Word cache with first-in-first-out replacement and a saturating miss count.
//
// req channel: one word per beat (req_valid/req_ready). rsp channel: one
// beat per request carrying rsp_miss (word was absent and has been inserted)
// and rsp_miss_total (misses since reset, this one included).
// csr: APB-style port; the capacity register sits at byte address 0.
//
// Each request runs down a row of ENTRIES cells, one cell per cycle, each
// cell comparing against the word it holds. The response is registered at
// the end of the row, and the next request is taken only after that
// response has been issued: a new word is not accepted before the last one
// is done, so the walk through the cell row sets the time per word.
//
// A finished response waits in an output register; a stalled rsp_ready
// holds it. The following request is still taken and walks the row, then
// waits at the end of it, and no further request is taken, until the
// pending beat has left. Reset empties the cache, clears the miss count,
// restores capacity to 128 and drops any beat in flight.
`default_nettype none
module fifo_cache_miss_counter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [fcmc_pkg::WORD_BITS-1:0]      req_word,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_miss,
   output logic [fcmc_pkg::COUNT_BITS-1:0]          rsp_miss_total,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [fcmc_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [fcmc_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [fcmc_pkg::CSR_DATA_BITS-1:0]       csr_prdata,
   output logic                                     csr_pready
);

   fcmc_pkg::probe_type             chain [fcmc_pkg::ENTRIES+1];
   fcmc_pkg::write_type             wr;
   logic [fcmc_pkg::OCC_BITS-1:0]   span;

   assign chain[0].valid = req_valid & req_ready;
   assign chain[0].hit   = 1'b0;
   assign chain[0].word  = req_word;

   for (genvar i = 0; i < fcmc_pkg::ENTRIES; i++) begin : g_cell
      fcmc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .slot_id (fcmc_pkg::SLOT_BITS'(i)),
         .span    (span),
         .probe_i (chain[i]),
         .wr      (wr),
         .probe_o (chain[i+1])
      );
   end

   fcmc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .probe_last     (chain[fcmc_pkg::ENTRIES]),
      .span           (span),
      .wr             (wr),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_miss       (rsp_miss),
      .rsp_miss_total (rsp_miss_total),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

endmodule
`default_nettype wire

>>> sv/fcmc_cell.sv
`default_nettype none
module fcmc_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [fcmc_pkg::SLOT_BITS-1:0] slot_id,
   input  wire logic [fcmc_pkg::OCC_BITS-1:0]  span,
   input  wire fcmc_pkg::probe_type           probe_i,
   input  wire fcmc_pkg::write_type           wr,
   output fcmc_pkg::probe_type                probe_o
);

   fcmc_pkg::probe_type                 probe_ff, probe_in;
   logic [fcmc_pkg::WORD_BITS-1:0]      stored_ff;
   logic                                active;

   assign active = fcmc_pkg::OCC_BITS'(slot_id) < span;

   always_comb begin
      probe_in       = probe_i;
      probe_in.hit   = probe_i.hit | (probe_i.valid & active & (stored_ff == probe_i.word));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.valid <= 1'b0;
      end else begin
         probe_ff.valid <= probe_in.valid;
      end
      probe_ff.hit  <= probe_in.hit;
      probe_ff.word <= probe_in.word;
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr.slot == slot_id)) begin
         stored_ff <= wr.word;
      end
   end

   assign probe_o = probe_ff;

endmodule
`default_nettype wire

>>> sv/fcmc_ctrl.sv
`default_nettype none
module fcmc_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire fcmc_pkg::probe_type               probe_last,
   output logic [fcmc_pkg::OCC_BITS-1:0]          span,
   output fcmc_pkg::write_type                    wr,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_miss,
   output logic [fcmc_pkg::COUNT_BITS-1:0]        rsp_miss_total,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [fcmc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [fcmc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [fcmc_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                   csr_pready
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]                      state_ff, state_in;
   logic [fcmc_pkg::CAP_BITS-1:0]   cap_ff;
   logic [fcmc_pkg::OCC_BITS-1:0]   occ_ff;
   logic [fcmc_pkg::SLOT_BITS-1:0]  oldest_ff;
   logic [fcmc_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic                            hit_ff;
   logic [fcmc_pkg::WORD_BITS-1:0]  word_ff;
   logic                            rsp_valid_ff, rsp_miss_ff;
   logic [fcmc_pkg::COUNT_BITS-1:0] rsp_total_ff;

   logic [fcmc_pkg::OCC_BITS-1:0]   cap_ext, cap_eff, old_ext, old_use, old_next, old_wrap;
   logic                            rsp_free, finish_go, fill, reg_sel, cfg_write;

   assign reg_sel   = csr_paddr[fcmc_pkg::CSR_ADDR_BITS-1:2] == fcmc_pkg::REG_CAPACITY;
   assign cfg_write = csr_psel & csr_penable & csr_pwrite & reg_sel;

   assign cap_ext = fcmc_pkg::OCC_BITS'(cap_ff);
   always_comb begin
      priority if (cap_ext == '0) begin
         cap_eff = fcmc_pkg::OCC_ONE;
      end else if (cap_ext > fcmc_pkg::OCC_ENTRIES) begin
         cap_eff = fcmc_pkg::OCC_ENTRIES;
      end else begin
         cap_eff = cap_ext;
      end
   end

   assign span     = (occ_ff < cap_eff) ? occ_ff : cap_eff;
   assign fill     = occ_ff < cap_eff;
   assign old_ext  = fcmc_pkg::OCC_BITS'(oldest_ff);
   assign old_use  = (old_ext >= cap_eff) ? '0 : old_ext;
   assign old_next = old_use + fcmc_pkg::OCC_ONE;
   assign old_wrap = (old_next >= cap_eff) ? '0 : old_next;
   assign count_in = (count_ff == fcmc_pkg::COUNT_MAX) ? count_ff
                                                       : count_ff + fcmc_pkg::COUNT_BITS'(1);

   assign rsp_free  = ~rsp_valid_ff | rsp_ready;
   assign finish_go = (state_ff == ST_FINISH) & rsp_free;

   always_comb begin
      wr.en   = finish_go & ~hit_ff;
      wr.slot = fill ? occ_ff[fcmc_pkg::SLOT_BITS-1:0] : old_use[fcmc_pkg::SLOT_BITS-1:0];
      wr.word = word_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (probe_last.valid) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= fcmc_pkg::CAP_RESET;
         occ_ff       <= '0;
         oldest_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cfg_write) begin
            cap_ff <= csr_pwdata[fcmc_pkg::CAP_BITS-1:0];
         end
         if (wr.en) begin
            if (fill) begin
               occ_ff <= occ_ff + fcmc_pkg::OCC_ONE;
            end else begin
               oldest_ff <= old_wrap[fcmc_pkg::SLOT_BITS-1:0];
            end
            count_ff <= count_in;
         end
         if (finish_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff != ST_FINISH) && probe_last.valid) begin
         hit_ff  <= probe_last.hit;
         word_ff <= probe_last.word;
      end
      if (finish_go) begin
         rsp_miss_ff  <= ~hit_ff;
         rsp_total_ff <= hit_ff ? count_ff : count_in;
      end
   end

   assign req_ready      = state_ff == ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_miss       = rsp_miss_ff;
   assign rsp_miss_total = rsp_total_ff;
   assign csr_prdata     = reg_sel ? fcmc_pkg::CSR_DATA_BITS'(cap_ff) : '0;
   assign csr_pready     = 1'b1;

endmodule
`default_nettype wire

>>> sv/fcmc_checker.sv
`default_nettype none
`include "assert_macros.svh"
module fcmc_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic                                rsp_miss,
   input wire logic [fcmc_pkg::COUNT_BITS-1:0]     rsp_miss_total
);

   `FCMC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_miss_total), "rsp beat dropped or changed while stalled")
   `FCMC_ASSERT_ALWAYS(a_rsp_reset, $past(reset) |-> !rsp_valid, "rsp valid right after reset")
   `FCMC_ASSERT(a_miss_counted, rsp_valid && rsp_miss |-> rsp_miss_total != '0, "miss with zero miss count")
   `FCMC_ASSERT(a_busy_after_req, req_valid && req_ready |=> !req_ready, "req taken while a lookup is in flight")

endmodule

bind fifo_cache_miss_counter fcmc_checker u_fcmc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_miss       (rsp_miss),
   .rsp_miss_total (rsp_miss_total)
);
`default_nettype wire

>>> bench/fifo_cache_miss_counter_test.sv
module fifo_cache_miss_counter_test;
   timeunit 1ns;
   timeprecision 1ps;
   import fcmc_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0] CAP_ADDR = CSR_ADDR_BITS'({REG_CAPACITY, 2'b00});
   localparam int unsigned DRAIN_LIMIT = (ENTRIES + 2) * 40;
   localparam int unsigned HOLD_CYCLES = 500;

   typedef struct {
      bit                  miss;
      bit [COUNT_BITS-1:0] total;
   } outcome_type;

   class cache_mirror;
      logic [WORD_BITS-1:0] slot_word [ENTRIES];
      int unsigned          fill;
      int unsigned          oldest;
      int unsigned          capacity;
      bit [COUNT_BITS-1:0]  misses;
      outcome_type          pending [$];
      int unsigned          faults;
      int unsigned          words_seen;
      int unsigned          hits_seen;

      function new();
         capacity = CAP_RESET;
      endfunction

      function void set_capacity(logic [CAP_BITS-1:0] value);
         capacity = value;
      endfunction

      function void fault(string what, longint unsigned want, longint unsigned got);
         faults++;
         if (faults <= 10) begin
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
         end
      endfunction

      function void note_word(logic [WORD_BITS-1:0] w);
         int unsigned cap;
         int unsigned span;
         bit          hit;
         outcome_type o;
         cap = capacity;
         if (cap == 0) cap = 1;
         if (cap > ENTRIES) cap = ENTRIES;
         span = (fill < cap) ? fill : cap;
         hit = 1'b0;
         for (int i = 0; i < span; i++) begin
            if (slot_word[i] == w) hit = 1'b1;
         end
         if (!hit) begin
            if (fill < cap) begin
               slot_word[fill] = w;
               fill++;
            end else begin
               if (oldest >= cap) oldest = 0;
               slot_word[oldest] = w;
               oldest++;
               if (oldest >= cap) oldest = 0;
            end
            if (misses != COUNT_MAX) misses++;
         end else begin
            hits_seen++;
         end
         words_seen++;
         o.miss  = !hit;
         o.total = misses;
         pending.push_back(o);
      endfunction

      function void check_outcome(logic miss, logic [COUNT_BITS-1:0] total);
         outcome_type want;
         if (pending.size() == 0) begin
            faults++;
            if (faults <= 10) begin
               $display("unexpected beat: miss %0b, miss_total %0h", miss, total);
            end
            return;
         end
         want = pending.pop_front();
         if (miss !== want.miss) fault("miss", want.miss, miss);
         if (total !== want.total) fault("miss_total", want.total, total);
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [WORD_BITS-1:0]     req_word;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic                     rsp_miss;
   logic [COUNT_BITS-1:0]    rsp_miss_total;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   cache_mirror mirror = new();
   bit          no_idle;
   int unsigned hold_len;
   int unsigned capacity_writes;

   fifo_cache_miss_counter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_miss       (rsp_miss),
      .rsp_miss_total (rsp_miss_total),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int unsigned n;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_len != 0) begin
            rsp_ready <= 1'b0;
            n = hold_len;
            hold_len = 0;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_ready <= no_idle || ($urandom_range(0, 99) >= 19);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) mirror.check_outcome(rsp_miss, rsp_miss_total);
   end

   task automatic send_word(input logic [WORD_BITS-1:0] w);
      while (!no_idle && $urandom_range(0, 99) < 19) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      mirror.note_word(w);
      @(negedge clock);
   endtask

   task automatic drain();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      while (mirror.pending.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (ENTRIES + 8) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] data;
      logic [CSR_DATA_BITS-1:0] readback;
      data = $urandom();
      data[CAP_BITS-1:0] = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CAP_ADDR;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      mirror.set_capacity(value);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback[CAP_BITS-1:0] !== value) mirror.fault("capacity readback", value, readback);
      capacity_writes++;
   endtask

   task automatic run_list(input logic [WORD_BITS-1:0] list [$]);
      foreach (list[i]) send_word(list[i]);
      drain();
   endtask

   task automatic run_phase(input logic [CAP_BITS-1:0] cap, input int unsigned count,
                            input bit hold);
      int unsigned          eff;
      int unsigned          pool;
      logic [WORD_BITS-1:0] base;
      logic [WORD_BITS-1:0] w;
      write_capacity(cap);
      eff = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : cap;
      pool = eff + eff / 2 + 1;
      base = $urandom_range(0, 65535);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 80) begin
            w = base + WORD_BITS'($urandom_range(0, pool - 1));
         end else begin
            w = $urandom_range(0, 65535);
         end
         if (hold && n == count / 3) hold_len = HOLD_CYCLES;
         send_word(w);
      end
      drain();
   endtask

   initial begin
      logic [CAP_BITS-1:0] caps [13];
      caps        = '{128, 2, 200, 1, 16, 0, 64, 5, 255, 3, 128, 32, 9};
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_word    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_list('{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000, 16'h0001,
                 16'h7FFF, 16'h5555, 16'hAAAA, 16'h8000});
      write_capacity(1);
      run_list('{16'h1234, 16'h1234, 16'h4321, 16'h1234});
      write_capacity(0);
      run_list('{16'h1234, 16'h9999});
      write_capacity(255);
      run_list('{16'hFFFF, 16'h9999, 16'h0000});
      write_capacity(6);
      run_list('{16'hA001, 16'hA002, 16'hA003, 16'hA004});
      write_capacity(3);
      run_list('{16'hB001, 16'hB001});

      foreach (caps[i]) begin
         no_idle = (i == 4 || i == 10);
         run_phase(caps[i], 127, i == 1 || i == 8);
      end
      no_idle = 1'b0;

      if (mirror.pending.size() != 0) begin
         mirror.faults += mirror.pending.size();
         $display("%0d results never arrived", mirror.pending.size());
      end
      $display("covered %0d words: %0d hits, %0d misses, %0d capacity writes",
               mirror.words_seen, mirror.hits_seen, mirror.misses, capacity_writes);
      $display("capacities spanned 0..255 with shrink, regrow and receiver hold-offs");
      if (mirror.faults == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> fifo_cache_miss_counter.f
+incdir+sv
sv/fcmc_pkg.sv
sv/fcmc_cell.sv
sv/fcmc_ctrl.sv
sv/fifo_cache_miss_counter.sv
sv/fcmc_checker.sv
bench/fifo_cache_miss_counter_test.sv
